### src/swr_pkg.sv
`timescale 1ns / 1ps

package swr_pkg;

   // field widths
   localparam int SEQ_W  = 32;
   localparam int LEN_W  = 11;
   localparam int KIND_W = 2;
   localparam int WIN_W  = 6;

   // ring size default and per-request delivery bound
   localparam int WINDOW_SLOTS_DEF = 32;
   localparam int DRAIN_LIMIT      = 32;

   typedef logic [SEQ_W-1:0]  seq_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [WIN_W-1:0]  win_type;

   // packet kinds
   localparam kind_type KIND_DATA = 2'd0;
   localparam kind_type KIND_END  = 2'd1;

   // result kinds
   localparam kind_type RES_DELIVER = 2'd0;
   localparam kind_type RES_ACK     = 2'd1;
   localparam kind_type RES_FINAL   = 2'd2;
   localparam kind_type RES_UNUSED  = 2'd3;

   // ack modes
   localparam logic MODE_CUMULATIVE = 1'b0;
   localparam logic MODE_SELECTIVE  = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_MODE = 1'd1;

endpackage

### src/swr_req_if.sv
`timescale 1ns / 1ps

interface swr_req_if
   import swr_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type kind;
   seq_type  seq_number;
   logic     check_ok;
   len_type  payload_length;

   modport source (output valid, kind, seq_number, check_ok, payload_length, input ready);
   modport sink   (input valid, kind, seq_number, check_ok, payload_length, output ready);
endinterface

### src/swr_rsp_if.sv
`timescale 1ns / 1ps

interface swr_rsp_if
   import swr_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type result_kind;
   seq_type  result_seq;
   len_type  result_length;
   logic     last;

   modport source (output valid, result_kind, result_seq, result_length, last, input ready);
   modport sink   (input valid, result_kind, result_seq, result_length, last, output ready);
endinterface

### src/sliding_window_receiver.sv
`timescale 1ns / 1ps

// Selective-repeat receiver window.
// req_ch carries one packet descriptor per request (kind, sequence number,
// checksum flag, payload length); rsp_ch returns the resulting deliveries
// and acks in order, with last set on the final result of each request.
// csr_we/csr_index/csr_wdata write the window span (index 0) and the ack
// mode (index 1); write them only while the block is idle.
// Sequencing: a request is taken only when the sequencer is idle. In
// cumulative mode it passes through evaluate, drain check, ack and idle,
// with a mark step when the packet is stored in the ring and, per delivered
// packet, a slot-length memory read, then output load (at most 32
// deliveries per request). Selective mode acks a good data packet before
// draining and sends no cumulative ack; a closing request goes from
// evaluate to the final ack, and a request after close straight to idle.
// Results sit in one output register; a new result loads when that
// register is empty or taken in the same cycle, so a stalled receiver
// holds the sequencer in place without losing anything.
// Reset (synchronous, active high) clears base, all slot valid bits, the
// closed flag and restores a span of 32 and cumulative mode. After a
// final ack the block accepts and drops every request.
module sliding_window_receiver
   import swr_pkg::*;
#(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   swr_req_if.sink              req_ch,
   swr_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  win_type              csr_wdata
);

   localparam int SLOT_W = $clog2(WINDOW_SLOTS);
   localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W+1)'(WINDOW_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);
   localparam win_type           SLOTS_WIN = WIN_W'(WINDOW_SLOTS);
   localparam logic [5:0]        DRAIN_MAX = 6'(DRAIN_LIMIT);
   localparam logic [5:0]        DRAIN_PRE = 6'(DRAIN_LIMIT - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EVAL      = 3'd1;
   localparam logic [2:0] S_MARK      = 3'd2;
   localparam logic [2:0] S_ACK_SEL   = 3'd3;
   localparam logic [2:0] S_DRAIN_CHK = 3'd4;
   localparam logic [2:0] S_DRAIN_OUT = 3'd5;
   localparam logic [2:0] S_ACK_CUM   = 3'd6;
   localparam logic [2:0] S_FINAL     = 3'd7;

   logic [2:0]        state_ff, state_in;
   win_type           window_ff;
   logic              mode_ff;
   seq_type           base_ff, base_in;
   logic [SLOT_W-1:0] base_idx_ff, base_idx_in;
   logic              closed_ff, closed_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic [5:0]        cnt_ff, cnt_in;

   // captured request
   kind_type          kind_ff;
   seq_type           seq_ff;
   logic              ok_ff;
   len_type           len_ff;
   logic [SLOT_W-1:0] diff_ff, diff_in;

   // slot length memory
   len_type           len_mem [WINDOW_SLOTS];
   len_type           mem_q_ff;
   logic              mem_we, mem_re;
   logic [SLOT_W-1:0] mem_waddr;

   // output register
   logic     out_valid_ff, out_valid_in;
   kind_type out_kind_ff, out_kind_in;
   seq_type  out_seq_ff, out_seq_in;
   len_type  out_len_ff, out_len_in;
   logic     out_last_ff, out_last_in;
   logic     out_load, out_free;

   // shared adder
   seq_type  alu_a, alu_b, alu_sum;
   logic     alu_cin;

   win_type           win_eff;
   logic              end_hit, in_win, data_ok, more, seq_wrap;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] slot_idx, next_idx;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result_kind = out_kind_ff;
   assign rsp_ch.result_seq  = out_seq_ff;
   assign rsp_ch.result_length = out_len_ff;
   assign rsp_ch.last        = out_last_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // one adder: offset from base during evaluation, base increment in drain
   always_comb begin
      if (state_ff == S_EVAL) begin
         alu_a   = seq_ff;
         alu_b   = ~base_ff;
         alu_cin = 1'b1;
      end else begin
         alu_a   = base_ff;
         alu_b   = '0;
         alu_cin = 1'b1;
      end
      alu_sum = alu_a + alu_b + SEQ_W'(alu_cin);
   end

   assign win_eff = (window_ff < SLOTS_WIN) ? window_ff : SLOTS_WIN;
   assign in_win  = (alu_sum[SEQ_W-1:WIN_W] == '0) && (alu_sum[WIN_W-1:0] < win_eff);
   assign end_hit = (kind_ff == KIND_END) && ok_ff && (seq_ff <= base_ff);
   assign data_ok = (kind_ff == KIND_DATA) && ok_ff;

   // ring position of the marked packet: offset stays below the ring size;
   // past the sequence wrap the packet number itself is below the ring size
   assign seq_wrap = (seq_ff < base_ff);
   assign slot_sum = {1'b0, base_idx_ff} + {1'b0, diff_ff};
   assign slot_idx = seq_wrap ? seq_ff[SLOT_W-1:0] :
                     (slot_sum >= SLOTS_X) ? SLOT_W'(slot_sum - SLOTS_X)
                                           : slot_sum[SLOT_W-1:0];

   // ring position of base + 1; sequence wrap restarts the ring at zero
   assign next_idx = (base_ff == '1) ? '0 :
                     (base_idx_ff == SLOT_LAST) ? '0 : SLOT_W'(base_idx_ff + 1'b1);

   // another delivery follows the current one in this request
   assign more = (cnt_ff < DRAIN_PRE) && valid_ff[next_idx] && (next_idx != base_idx_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      base_idx_in  = base_idx_ff;
      closed_in    = closed_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      diff_in      = diff_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = slot_idx;
      out_load     = 1'b0;
      out_kind_in  = out_kind_ff;
      out_seq_in   = out_seq_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cnt_in  = '0;
            diff_in = alu_sum[SLOT_W-1:0];
            priority if (closed_ff) begin
               state_in = S_IDLE;
            end else if (end_hit) begin
               state_in = S_FINAL;
            end else if (data_ok && in_win) begin
               state_in = S_MARK;
            end else if (data_ok && (mode_ff == MODE_SELECTIVE)) begin
               state_in = S_ACK_SEL;
            end else begin
               state_in = S_DRAIN_CHK;
            end
         end
         S_MARK: begin
            mem_we             = 1'b1;
            valid_in[slot_idx] = 1'b1;
            state_in = (mode_ff == MODE_SELECTIVE) ? S_ACK_SEL : S_DRAIN_CHK;
         end
         S_ACK_SEL: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = RES_ACK;
               out_seq_in  = seq_ff;
               out_len_in  = '0;
               out_last_in = !valid_ff[base_idx_ff];
               state_in    = S_DRAIN_CHK;
            end
         end
         S_DRAIN_CHK: begin
            if ((cnt_ff < DRAIN_MAX) && valid_ff[base_idx_ff]) begin
               mem_re   = 1'b1;
               state_in = S_DRAIN_OUT;
            end else begin
               state_in = (mode_ff == MODE_SELECTIVE) ? S_IDLE : S_ACK_CUM;
            end
         end
         S_DRAIN_OUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = RES_DELIVER;
               out_seq_in  = base_ff;
               out_len_in  = mem_q_ff;
               out_last_in = (mode_ff == MODE_SELECTIVE) && !more;
               valid_in[base_idx_ff] = 1'b0;
               base_in     = alu_sum;
               base_idx_in = next_idx;
               cnt_in      = cnt_ff + 1'b1;
               state_in    = S_DRAIN_CHK;
            end
         end
         S_ACK_CUM: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = RES_ACK;
               out_seq_in  = base_ff;
               out_len_in  = '0;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = RES_FINAL;
               out_seq_in  = base_ff;
               out_len_in  = '0;
               out_last_in = 1'b1;
               closed_in   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         base_idx_ff  <= '0;
         closed_ff    <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         base_idx_ff  <= base_idx_in;
         closed_ff    <= closed_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(32);
         mode_ff   <= MODE_CUMULATIVE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN:     window_ff <= csr_wdata;
            CSR_ACK_MODE: mode_ff   <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         kind_ff <= req_ch.kind;
         seq_ff  <= req_ch.seq_number;
         ok_ff   <= req_ch.check_ok;
         len_ff  <= req_ch.payload_length;
      end
      diff_ff <= diff_in;
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_seq_ff  <= out_seq_in;
         out_len_ff  <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   // slot length memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[mem_waddr] <= len_ff;
      end
      if (mem_re) begin
         mem_q_ff <= len_mem[base_idx_ff];
      end
   end

endmodule

### src/swr_checker.sv
`timescale 1ns / 1ps

module swr_checker
   import swr_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input kind_type rsp_kind,
   input seq_type  rsp_seq,
   input len_type  rsp_length,
   input logic     rsp_last
);

   // a taken request leaves the sequencer busy in the cycle after it
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_seq)
          && $stable(rsp_length) && $stable(rsp_last)))
      else $error("stalled result changed");

   // acks carry no length and the unused kind code never appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == RES_DELIVER) || ((rsp_kind != RES_UNUSED) && (rsp_length == '0))))
      else $error("bad result kind or ack length");

   // the closing ack is always the last result of its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == RES_FINAL)) |-> rsp_last)
      else $error("final ack without last");

endmodule

bind sliding_window_receiver swr_checker u_swr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.result_kind),
   .rsp_seq    (rsp_ch.result_seq),
   .rsp_length (rsp_ch.result_length),
   .rsp_last   (rsp_ch.last)
);
